// ----- rtl/moving_average_pid_duty_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the moving-average PID duty controller
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_PID_DUTY_TOP_DEFINES_SVH
`define MOVING_AVERAGE_PID_DUTY_TOP_DEFINES_SVH

// Check on every clock edge outside reset
`define MAPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check on every clock edge, reset included
`define MAPD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/mapd_pkg.sv -----
// ----------------------------------------------------------------------------
// Moving-average PID duty controller package
// Field widths, register indexes, reset values, codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package mapd_pkg;

    // Field and datapath widths
    localparam int ADC_W      = 12;
    localparam int ERR_W      = 13;
    localparam int DERR_W     = 14;
    localparam int GAIN_W     = 24;
    localparam int LIM_W      = 47;
    localparam int INTEG_W    = 48;
    localparam int ISUM_W     = 49;
    localparam int DUTY_W     = 16;
    localparam int MUL_W      = 24;
    localparam int PROD_W     = 48;
    localparam int ACC_W      = 73;
    localparam int ACC_SHIFT  = 24;
    localparam int FRAC_W     = 40;
    localparam int Q_W        = ACC_W - FRAC_W;
    localparam int SAT_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 47;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MIN      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX      = 3'd7;

    // Saturation codes
    localparam logic [SAT_W-1:0] SAT_NONE = 2'd0;
    localparam logic [SAT_W-1:0] SAT_HIGH = 2'd1;
    localparam logic [SAT_W-1:0] SAT_LOW  = 2'd2;

    typedef struct packed {
        logic [ADC_W-1:0]  setpoint;
        logic [GAIN_W-1:0] gain_prop;
        logic [GAIN_W-1:0] gain_integ;
        logic [GAIN_W-1:0] gain_deriv;
        logic [GAIN_W-1:0] sample_period;
        logic [LIM_W-1:0]  integ_limit;
        logic [DUTY_W-1:0] duty_min;
        logic [DUTY_W-1:0] duty_max;
    } t_cfg;

    localparam t_cfg CFG_RST = '{
        setpoint:      12'd1830,
        gain_prop:     24'd16384,
        gain_integ:    24'd393216,
        gain_deriv:    24'd655,
        sample_period: 24'd16777,
        integ_limit:   47'd16777216,
        duty_min:      16'd0,
        duty_max:      16'd65535
    };

    // Window status toward the PID sequencer
    typedef struct packed {
        logic running;   // window full, every new sample yields a result
        logic done;      // running sum holds the sum after the last sample
    } t_win_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WAIT,
        S_AVG,
        S_ERR,
        S_MI,
        S_MP,
        S_MD,
        S_MH,
        S_ML,
        S_SUMLO,
        S_TRUNC,
        S_SAT
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/mapd_mul.sv -----
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 24x24 multiply with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module mapd_mul (
    input  wire logic                         i_clk,
    input  wire logic [mapd_pkg::MUL_W-1:0]   i_a,
    input  wire logic [mapd_pkg::MUL_W-1:0]   i_b,
    output logic      [mapd_pkg::PROD_W-1:0]  o_p
);
    import mapd_pkg::*;

    logic [PROD_W-1:0] r_p;

    // Register the product
    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ----- rtl/mapd_win.sv -----
// ----------------------------------------------------------------------------
// Averaging window ring
// Sample ring in a synchronous memory with running sum, write pointer and
// fill count. Once full, each sample reads the oldest entry, then writes the
// new sample over it and updates the sum on the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mapd_win #(
    parameter int WINDOW_DEPTH = 16,
    parameter int SAMPLE_W     = 12
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_push,
    input  wire logic [SAMPLE_W-1:0]                       i_sample,
    output mapd_pkg::t_win_stat                            o_stat,
    output logic [SAMPLE_W+$clog2(WINDOW_DEPTH)-1:0]       o_sum
);
    import mapd_pkg::*;

    localparam int POS_W  = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = SAMPLE_W + POS_W;

    logic [SAMPLE_W-1:0] r_mem [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;
    logic [SAMPLE_W-1:0] r_hold;
    logic [POS_W-1:0]    r_pos;
    logic [FILL_W-1:0]   r_fill;
    logic [SUM_W-1:0]    r_sum;
    logic                r_busy;
    logic                r_done;

    logic                running;
    logic                wr_en;
    logic [SAMPLE_W-1:0] wr_data;
    logic [POS_W-1:0]    n_pos;
    logic [SUM_W-1:0]    n_sum;

    assign running = (r_fill == FILL_W'(WINDOW_DEPTH));

    // Write a fill sample at once, a running sample after its old entry is read
    assign wr_en   = (i_push && !running) || r_busy;
    assign wr_data = r_busy ? r_hold : i_sample;

    // Advance the ring pointer with wrap
    assign n_pos = (r_pos == POS_W'(WINDOW_DEPTH - 1)) ? '0 : r_pos + 1'b1;

    // Drop the oldest sample and add the new one
    always_comb begin
        if (r_busy) begin
            n_sum = r_sum - SUM_W'(r_rdata) + SUM_W'(r_hold);
        end else begin
            n_sum = r_sum + SUM_W'(i_sample);
        end
    end

    // Ring memory: write and registered read at the ring pointer
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_pos] <= wr_data;
        end
        r_rdata <= r_mem[r_pos];
    end

    // Hold the running sample while the old entry is read
    always_ff @(posedge i_clk) begin
        if (i_push && running) begin
            r_hold <= i_sample;
        end
    end

    // Pointer, fill count and sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_fill <= '0;
            r_sum  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy;
            if (r_busy) begin
                r_sum  <= n_sum;
                r_pos  <= n_pos;
                r_busy <= 1'b0;
            end else if (i_push) begin
                if (running) begin
                    r_busy <= 1'b1;
                end else begin
                    r_sum  <= n_sum;
                    r_pos  <= n_pos;
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    assign o_stat.running = running;
    assign o_stat.done    = r_done;
    assign o_sum          = r_sum;

endmodule

`default_nettype wire

// ----- rtl/mapd_ctrl.sv -----
// ----------------------------------------------------------------------------
// PID sequencer
// Steps one sample through average, error, integral update and clamp, the
// PID sum on the shared multiplier, truncation and duty clamp, then loads
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mapd_ctrl #(
    parameter int WINDOW_DEPTH = 16,
    parameter int SAMPLE_W     = 12
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire mapd_pkg::t_cfg                        i_cfg,
    input  wire logic                                  i_accept,
    input  wire mapd_pkg::t_win_stat                   i_win,
    input  wire logic [SAMPLE_W+$clog2(WINDOW_DEPTH)-1:0] i_sum,
    output logic [mapd_pkg::MUL_W-1:0]                 o_mul_a,
    output logic [mapd_pkg::MUL_W-1:0]                 o_mul_b,
    input  wire logic [mapd_pkg::PROD_W-1:0]           i_mul_p,
    output logic                                       o_in_ready,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [mapd_pkg::DUTY_W-1:0]                o_duty,
    output logic [mapd_pkg::ADC_W-1:0]                 o_filtered,
    output logic signed [mapd_pkg::ERR_W-1:0]          o_ctrl_error,
    output logic [mapd_pkg::SAT_W-1:0]                 o_sat_code
);
    import mapd_pkg::*;

    // Average by reciprocal multiply: exact floor for every reachable sum
    localparam int AVG_L     = $clog2(WINDOW_DEPTH);
    localparam int SUM_W     = SAMPLE_W + AVG_L;
    localparam int AVG_SHIFT = SUM_W + AVG_L;
    localparam logic [63:0] AVG_MULT =
        ((64'd1 << AVG_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;

    t_state r_state, n_state;

    logic [ADC_W-1:0]          r_avg;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [ERR_W-1:0]   r_prev;
    logic signed [DERR_W-1:0]  r_derr;
    logic signed [ISUM_W-1:0]  r_isum;
    logic signed [INTEG_W-1:0] r_integ;
    logic [LIM_W-1:0]          r_mag;
    logic                      r_ineg;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [Q_W-1:0]     r_q;
    logic                      r_out_valid;
    logic [DUTY_W-1:0]         r_duty;
    logic [ADC_W-1:0]          r_filt;
    logic signed [ERR_W-1:0]   r_err_out;
    logic [SAT_W-1:0]          r_sat;

    logic [ADC_W-1:0]          avg_val;
    logic signed [ERR_W-1:0]   err_val;
    logic [ERR_W-1:0]          err_abs;
    logic signed [DERR_W-1:0]  derr_val;
    logic [DERR_W-1:0]         derr_abs;
    logic signed [ISUM_W-1:0]  prod_isum;
    logic signed [ISUM_W-1:0]  isum_val;
    logic signed [ISUM_W-1:0]  lim_pos;
    logic signed [ISUM_W-1:0]  lim_neg;
    logic signed [INTEG_W-1:0] integ_clamp;
    logic [INTEG_W-1:0]        integ_neg;
    logic [ACC_W-1:0]          prod_z;
    logic signed [ACC_W-1:0]   acc_base;
    logic signed [ACC_W-1:0]   acc_term;
    logic signed [ACC_W-1:0]   acc_sum;
    logic                      acc_sub;
    logic signed [Q_W-1:0]     q_floor;
    logic signed [Q_W-1:0]     q_val;
    logic                      frac_nz;
    logic signed [Q_W-1:0]     dmax_s;
    logic signed [Q_W-1:0]     dmin_s;
    logic [DUTY_W-1:0]         duty_val;
    logic [SAT_W-1:0]          sat_val;
    logic                      out_free;

    // Average and error from the reciprocal product
    assign avg_val = ADC_W'(i_mul_p[AVG_SHIFT +: SAMPLE_W]);
    assign err_val = signed'({1'b0, i_cfg.setpoint}) - signed'({1'b0, avg_val});
    assign err_abs = r_err[ERR_W-1] ? ERR_W'(-r_err) : ERR_W'(r_err);

    // Error change since the previous result
    assign derr_val = DERR_W'(r_err) - DERR_W'(r_prev);
    assign derr_abs = r_derr[DERR_W-1] ? DERR_W'(-r_derr) : DERR_W'(r_derr);

    // Integral step and clamp
    assign prod_isum = signed'(ISUM_W'(i_mul_p));
    assign isum_val  = r_err[ERR_W-1] ? ISUM_W'(r_integ) - prod_isum
                                      : ISUM_W'(r_integ) + prod_isum;
    assign lim_pos   = signed'(ISUM_W'(i_cfg.integ_limit));
    assign lim_neg   = -lim_pos;

    always_comb begin
        priority if (r_isum > lim_pos) begin
            integ_clamp = INTEG_W'(lim_pos);
        end else if (r_isum < lim_neg) begin
            integ_clamp = INTEG_W'(lim_neg);
        end else begin
            integ_clamp = INTEG_W'(r_isum);
        end
    end

    assign integ_neg = INTEG_W'(-r_integ);

    // Accumulate signed partial products of the PID sum
    assign prod_z = ACC_W'(i_mul_p);

    always_comb begin
        acc_base = r_acc;
        acc_term = '0;
        acc_sub  = 1'b0;
        unique case (r_state)
            S_MP: begin
                acc_base = '0;
                acc_term = signed'(prod_z << ACC_SHIFT);
                acc_sub  = r_err[ERR_W-1];
            end
            S_MD: begin
                acc_term = signed'(prod_z << ACC_SHIFT);
                acc_sub  = r_derr[DERR_W-1];
            end
            S_ML: begin
                acc_term = signed'(prod_z << ACC_SHIFT);
                acc_sub  = r_ineg;
            end
            S_SUMLO: begin
                acc_term = signed'(prod_z);
                acc_sub  = r_ineg;
            end
            default: begin
                acc_term = '0;
            end
        endcase
    end

    assign acc_sum = acc_sub ? acc_base - acc_term : acc_base + acc_term;

    // Truncate toward zero: floor, then bump negative values with a fraction
    assign q_floor = signed'(r_acc[ACC_W-1:FRAC_W]);
    assign frac_nz = |r_acc[FRAC_W-1:0];
    assign q_val   = q_floor + signed'(Q_W'(r_acc[ACC_W-1] & frac_nz));

    // Duty clamp, upper limit first
    assign dmax_s = signed'(Q_W'(i_cfg.duty_max));
    assign dmin_s = signed'(Q_W'(i_cfg.duty_min));

    always_comb begin
        priority if (r_q > dmax_s) begin
            duty_val = i_cfg.duty_max;
            sat_val  = SAT_HIGH;
        end else if (r_q < dmin_s) begin
            duty_val = i_cfg.duty_min;
            sat_val  = SAT_LOW;
        end else begin
            duty_val = r_q[DUTY_W-1:0];
            sat_val  = SAT_NONE;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and multiplier operands
    always_comb begin
        n_state = r_state;
        o_mul_a = '0;
        o_mul_b = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept && i_win.running) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_win.done) begin
                    o_mul_a = MUL_W'(i_sum);
                    o_mul_b = MUL_W'(AVG_MULT);
                    n_state = S_AVG;
                end
            end
            S_AVG: begin
                n_state = S_ERR;
            end
            S_ERR: begin
                o_mul_a = MUL_W'(err_abs);
                o_mul_b = i_cfg.sample_period;
                n_state = S_MI;
            end
            S_MI: begin
                o_mul_a = MUL_W'(err_abs);
                o_mul_b = i_cfg.gain_prop;
                n_state = S_MP;
            end
            S_MP: begin
                o_mul_a = MUL_W'(derr_abs);
                o_mul_b = i_cfg.gain_deriv;
                n_state = S_MD;
            end
            S_MD: begin
                n_state = S_MH;
            end
            S_MH: begin
                o_mul_a = MUL_W'(r_mag[LIM_W-1:ACC_SHIFT]);
                o_mul_b = i_cfg.gain_integ;
                n_state = S_ML;
            end
            S_ML: begin
                o_mul_a = MUL_W'(r_mag[ACC_SHIFT-1:0]);
                o_mul_b = i_cfg.gain_integ;
                n_state = S_SUMLO;
            end
            S_SUMLO: begin
                n_state = S_TRUNC;
            end
            S_TRUNC: begin
                n_state = S_SAT;
            end
            S_SAT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ     <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_SAT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_AVG: begin
                    r_avg <= avg_val;
                    r_err <= err_val;
                end
                S_ERR: begin
                    r_derr <= derr_val;
                    r_prev <= r_err;
                end
                S_MI: begin
                    r_isum <= isum_val;
                end
                S_MP: begin
                    r_integ <= integ_clamp;
                    r_acc   <= acc_sum;
                end
                S_MD: begin
                    r_acc  <= acc_sum;
                    r_ineg <= r_integ[INTEG_W-1];
                    r_mag  <= r_integ[INTEG_W-1] ? integ_neg[LIM_W-1:0]
                                                 : r_integ[LIM_W-1:0];
                end
                S_ML, S_SUMLO: begin
                    r_acc <= acc_sum;
                end
                S_TRUNC: begin
                    r_q <= q_val;
                end
                S_SAT: begin
                    if (out_free) begin
                        r_duty    <= duty_val;
                        r_sat     <= sat_val;
                        r_filt    <= r_avg;
                        r_err_out <= r_err;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_duty       = r_duty;
    assign o_filtered   = r_filt;
    assign o_ctrl_error = r_err_out;
    assign o_sat_code   = r_sat;

endmodule

`default_nettype wire

// ----- rtl/moving_average_pid_duty_top.sv -----
// ----------------------------------------------------------------------------
// Moving-average PID duty controller
// Each accepted converter sample enters a WINDOW_DEPTH-entry averaging ring.
// The first WINDOW_DEPTH samples after reset only fill the ring: they are
// taken one per cycle and give no result. Every later sample runs from its
// accepting cycle through the ring read-modify-write in its memory, the
// shared 24x24 multiplier and the 73-bit PID accumulator (average, error,
// integral step and clamp, four gain products, truncation toward zero), and
// the duty clamp and the load of the result register before the next
// request is taken. A finished result waits in its output register while
// the next sample is already taken; if it is still waiting when the next
// result is ready, the sequencer holds until it is taken.
// Configuration writes are registered; write them only while no sample
// is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_pid_duty_top #(
    parameter int WINDOW_DEPTH = 16,
    parameter int SAMPLE_BITS  = 12
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [mapd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [mapd_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic [mapd_pkg::ADC_W-1:0]            i_adc_sample,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [mapd_pkg::DUTY_W-1:0]                o_duty,
    output logic [mapd_pkg::ADC_W-1:0]                 o_filtered,
    output logic signed [mapd_pkg::ERR_W-1:0]          o_ctrl_error,
    output logic [mapd_pkg::SAT_W-1:0]                 o_sat_code
);
    import mapd_pkg::*;

    localparam int SAMPLE_W = (SAMPLE_BITS < ADC_W) ? SAMPLE_BITS : ADC_W;
    localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW_DEPTH);

    t_cfg              r_cfg;
    t_win_stat         win_stat;
    logic [SUM_W-1:0]  win_sum;
    logic              accept;
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_p;

    assign accept = i_in_valid && o_in_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_SETPOINT:      r_cfg.setpoint      <= i_cfg_wdata[ADC_W-1:0];
                CFG_GAIN_PROP:     r_cfg.gain_prop     <= i_cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_INTEG:    r_cfg.gain_integ    <= i_cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_DERIV:    r_cfg.gain_deriv    <= i_cfg_wdata[GAIN_W-1:0];
                CFG_SAMPLE_PERIOD: r_cfg.sample_period <= i_cfg_wdata[GAIN_W-1:0];
                CFG_INTEG_LIMIT:   r_cfg.integ_limit   <= i_cfg_wdata[LIM_W-1:0];
                CFG_DUTY_MIN:      r_cfg.duty_min      <= i_cfg_wdata[DUTY_W-1:0];
                CFG_DUTY_MAX:      r_cfg.duty_max      <= i_cfg_wdata[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mapd_win #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_W     (SAMPLE_W)
    ) u_win (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_sample (i_adc_sample[SAMPLE_W-1:0]),
        .o_stat   (win_stat),
        .o_sum    (win_sum)
    );

    mapd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    mapd_ctrl #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_W     (SAMPLE_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (accept),
        .i_win        (win_stat),
        .i_sum        (win_sum),
        .o_mul_a      (mul_a),
        .o_mul_b      (mul_b),
        .i_mul_p      (mul_p),
        .o_in_ready   (o_in_ready),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_duty       (o_duty),
        .o_filtered   (o_filtered),
        .o_ctrl_error (o_ctrl_error),
        .o_sat_code   (o_sat_code)
    );

endmodule

`default_nettype wire

// ----- rtl/mapd_chk.sv -----
// ----------------------------------------------------------------------------
// Port checker for the moving-average PID duty controller
// Watches the top-level ports for result handling and reset behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "moving_average_pid_duty_top_defines.svh"

module mapd_chk (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    input  wire logic                                  o_in_ready,
    input  wire logic                                  o_out_valid,
    input  wire logic                                  i_out_ready,
    input  wire logic [mapd_pkg::DUTY_W-1:0]           o_duty,
    input  wire logic [mapd_pkg::ADC_W-1:0]            o_filtered,
    input  wire logic signed [mapd_pkg::ERR_W-1:0]     o_ctrl_error,
    input  wire logic [mapd_pkg::SAT_W-1:0]            o_sat_code
);

    // Hold a stalled result and its payload until it is taken
    `MAPD_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_duty) && $stable(o_filtered) && $stable(o_ctrl_error) && $stable(o_sat_code), "stalled result dropped or changed")

    // Leave reset ready for a request with no result pending
    `MAPD_ASSERT_ALWAYS(a_rst_state, !i_rst_n |=> o_in_ready && !o_out_valid, "bad state after reset")

    // A result never shows up on the cycle right after a request
    `MAPD_ASSERT(a_no_shortcut, $rose(o_out_valid) |-> !$past(i_in_valid && o_in_ready), "result bypassed the PID sequence")

endmodule

bind moving_average_pid_duty_top mapd_chk u_mapd_chk (.*);

`default_nettype wire

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// Testbench for the moving-average PID duty controller
// Drives converter samples over a valid/ready request channel and collects
// duty results on a second one, both with random idle cycles. A scoreboard
// class tracks its own copy of the window, integral and registers. It
// predicts each duty, average, error and saturation code exactly, and
// compares every result in order. Registers are rewritten between phases
// while the block is idle, and the phases cover reset values, moderate
// gains, all-zero and all-ones settings, crossed duty limits and random
// settings.
// ----------------------------------------------------------------------------

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mapd_pkg::*;

    localparam int WIN_DEPTH     = 16;
    localparam int SMP_BITS      = 12;
    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 32;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 50;
    localparam int IDLE_PERCENT  = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int ADC_MAX       = (1 << ADC_W) - 1;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [DUTY_W-1:0]        duty;
        logic [ADC_W-1:0]         filtered;
        logic signed [ERR_W-1:0]  ctrl_error;
        logic [SAT_W-1:0]         sat_code;
    } duty_result_t;

    typedef enum int {
        CFG_KIND_RESET,
        CFG_KIND_MODERATE,
        CFG_KIND_ZERO,
        CFG_KIND_FULL,
        CFG_KIND_RANDOM
    } cfg_kind_t;

    // Tracks controller state and holds the duty results still owed
    class duty_scoreboard;
        t_cfg                cfg;
        logic [ADC_W-1:0]    ring [WIN_DEPTH];
        logic [15:0]         ring_sum;
        int unsigned         wr_pos;
        int unsigned         fill_count;
        longint              integ;
        longint              prev_err;
        duty_result_t        pending_duty [$];
        int unsigned         fail_count;

        function new();
            cfg        = CFG_RST;
            ring_sum   = '0;
            wr_pos     = 0;
            fill_count = 0;
            integ      = 0;
            prev_err   = 0;
            fail_count = 0;
        endfunction

        function int pending();
            return pending_duty.size();
        endfunction

        // Advance the controller by one accepted sample request
        function void step_controller(input logic [ADC_W-1:0] s);
            longint       avg;
            longint       err;
            longint       lim;
            wide_t        acc;
            wide_t        q;
            duty_result_t want;
            if (fill_count < WIN_DEPTH) begin
                ring[wr_pos] = s;
                ring_sum     = ring_sum + 16'(s);
                wr_pos       = (wr_pos == WIN_DEPTH - 1) ? 0 : wr_pos + 1;
                fill_count++;
                return;
            end
            // Replace the oldest entry and update the running sum
            ring_sum     = ring_sum - 16'(ring[wr_pos]) + 16'(s);
            ring[wr_pos] = s;
            wr_pos       = (wr_pos == WIN_DEPTH - 1) ? 0 : wr_pos + 1;

            avg = longint'(ring_sum) / WIN_DEPTH;
            err = longint'(cfg.setpoint) - avg;

            // Integrate and clamp to the symmetric limit
            lim   = longint'(cfg.integ_limit);
            integ = integ + err * longint'(cfg.sample_period);
            if (integ > lim)  integ = lim;
            if (integ < -lim) integ = -lim;

            // Full-precision PID sum scaled by 2^40, truncated toward zero
            acc = wide_t'(longint'(cfg.gain_prop) * err
                          + longint'(cfg.gain_deriv) * (err - prev_err));
            acc = (acc <<< ACC_SHIFT)
                  + wide_t'(longint'(cfg.gain_integ)) * wide_t'(integ);
            q   = acc / (wide_t'(1) <<< FRAC_W);
            prev_err = err;

            // Upper limit wins when the limits are crossed
            if (q > wide_t'(longint'(cfg.duty_max))) begin
                want.duty     = cfg.duty_max;
                want.sat_code = SAT_HIGH;
            end else if (q < wide_t'(longint'(cfg.duty_min))) begin
                want.duty     = cfg.duty_min;
                want.sat_code = SAT_LOW;
            end else begin
                want.duty     = q[DUTY_W-1:0];
                want.sat_code = SAT_NONE;
            end
            want.filtered   = ADC_W'(avg);
            want.ctrl_error = ERR_W'(err);
            pending_duty.push_back(want);
        endfunction

        // Compare one accepted result against the oldest prediction
        function void check_duty(input duty_result_t got);
            duty_result_t want;
            if (pending_duty.size() == 0) begin
                $display("%0t: unexpected result, expected none, got duty %0d",
                         $time, got.duty);
                fail_count++;
                return;
            end
            want = pending_duty.pop_front();
            if (got.duty !== want.duty) begin
                $display("%0t: duty mismatch, expected %0d, got %0d",
                         $time, want.duty, got.duty);
                fail_count++;
            end
            if (got.filtered !== want.filtered) begin
                $display("%0t: filtered mismatch, expected %0d, got %0d",
                         $time, want.filtered, got.filtered);
                fail_count++;
            end
            if (got.ctrl_error !== want.ctrl_error) begin
                $display("%0t: ctrl_error mismatch, expected %0d, got %0d",
                         $time, want.ctrl_error, got.ctrl_error);
                fail_count++;
            end
            if (got.sat_code !== want.sat_code) begin
                $display("%0t: sat_code mismatch, expected %0d, got %0d",
                         $time, want.sat_code, got.sat_code);
                fail_count++;
            end
        endfunction
    endclass

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index   = CFG_SETPOINT;
    logic [CFG_DATA_W-1:0]   cfg_wdata   = '0;
    logic                    in_valid    = 1'b0;
    logic [ADC_W-1:0]        in_sample   = '0;
    logic                    out_ready   = 1'b0;
    logic                    idle_on     = 1'b1;
    int unsigned             cycle_count = 0;

    logic                    in_ready;
    logic                    out_valid;
    logic [DUTY_W-1:0]       duty;
    logic [ADC_W-1:0]        filtered;
    logic signed [ERR_W-1:0] ctrl_error;
    logic [SAT_W-1:0]        sat_code;

    duty_scoreboard sb = new();

    moving_average_pid_duty_top #(
        .WINDOW_DEPTH (WIN_DEPTH),
        .SAMPLE_BITS  (SMP_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_adc_sample (in_sample),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_duty       (duty),
        .o_filtered   (filtered),
        .o_ctrl_error (ctrl_error),
        .o_sat_code   (sat_code)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Stall the result channel at random while idling is enabled
    always @(posedge i_clk) begin
        out_ready <= idle_on ? ($urandom_range(0, 99) >= IDLE_PERCENT) : 1'b1;
    end

    // Record accepted requests on both channels
    always @(posedge i_clk) begin
        duty_result_t got;
        if (i_rst_n) begin
            if (in_valid && in_ready) sb.step_controller(in_sample);
            if (out_valid && out_ready) begin
                got.duty       = duty;
                got.filtered   = filtered;
                got.ctrl_error = ctrl_error;
                got.sat_code   = sat_code;
                sb.check_duty(got);
            end
        end
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Present one sample request and hold it until accepted
    task automatic send_sample(input logic [ADC_W-1:0] s);
        if (idle_on) begin
            while ($urandom_range(0, 99) < IDLE_PERCENT) begin
                in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_valid  <= 1'b1;
        in_sample <= s;
        do @(posedge i_clk); while (!in_ready);
    endtask

    // Hold off the sender until every owed result has arrived
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    // Drain, let the block go quiet, then rewrite every register
    task automatic apply_config(input t_cfg c);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        put_reg(CFG_SETPOINT,      CFG_DATA_W'(c.setpoint));
        put_reg(CFG_GAIN_PROP,     CFG_DATA_W'(c.gain_prop));
        put_reg(CFG_GAIN_INTEG,    CFG_DATA_W'(c.gain_integ));
        put_reg(CFG_GAIN_DERIV,    CFG_DATA_W'(c.gain_deriv));
        put_reg(CFG_SAMPLE_PERIOD, CFG_DATA_W'(c.sample_period));
        put_reg(CFG_INTEG_LIMIT,   CFG_DATA_W'(c.integ_limit));
        put_reg(CFG_DUTY_MIN,      CFG_DATA_W'(c.duty_min));
        put_reg(CFG_DUTY_MAX,      CFG_DATA_W'(c.duty_max));
        cfg_wr_en <= 1'b0;
        sb.cfg = c;
    endtask

    function automatic t_cfg make_config(input cfg_kind_t kind);
        t_cfg        c;
        logic [63:0] r64;
        r64 = {$urandom(), $urandom()};
        c   = CFG_RST;
        case (kind)
            CFG_KIND_MODERATE: begin
                c.setpoint      = ADC_W'($urandom_range(0, ADC_MAX));
                c.gain_prop     = GAIN_W'($urandom_range(0, 1 << 18));
                c.gain_integ    = GAIN_W'($urandom_range(0, 1 << 20));
                c.gain_deriv    = GAIN_W'($urandom_range(0, 1 << 16));
                c.sample_period = GAIN_W'($urandom_range(0, 1 << 16));
                c.integ_limit   = LIM_W'(r64[35:0]);
                c.duty_min      = DUTY_W'($urandom_range(0, 20000));
                c.duty_max      = DUTY_W'($urandom_range(25000, 65535));
            end
            CFG_KIND_ZERO: begin
                c = '0;
            end
            CFG_KIND_FULL: begin
                c = '1;
            end
            CFG_KIND_RANDOM: begin
                c.setpoint      = ADC_W'($urandom());
                c.gain_prop     = GAIN_W'($urandom());
                c.gain_integ    = GAIN_W'($urandom());
                c.gain_deriv    = GAIN_W'($urandom());
                c.sample_period = GAIN_W'($urandom());
                c.integ_limit   = r64[LIM_W-1:0];
                c.duty_min      = DUTY_W'($urandom());
                c.duty_max      = DUTY_W'($urandom());
            end
            default: begin
                c = CFG_RST;
            end
        endcase
        return c;
    endfunction

    // Mix extremes, uniform values and values near the setpoint
    function automatic logic [ADC_W-1:0] pick_sample(input logic [ADC_W-1:0] target);
        int v;
        case ($urandom_range(0, 9))
            0:          v = 0;
            1:          v = ADC_MAX;
            2, 3, 4, 5: v = int'($urandom_range(0, ADC_MAX));
            default:    v = int'(target) + int'($urandom_range(0, 128)) - 64;
        endcase
        if (v < 0)       v = 0;
        if (v > ADC_MAX) v = ADC_MAX;
        return ADC_W'(v);
    endfunction

    initial begin
        t_cfg      c;
        cfg_kind_t plan [RANDOM_PHASES];
        plan = '{CFG_KIND_RESET, CFG_KIND_MODERATE, CFG_KIND_FULL, CFG_KIND_MODERATE,
                 CFG_KIND_ZERO, CFG_KIND_RANDOM, CFG_KIND_MODERATE, CFG_KIND_RANDOM};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the window with extremes and alternating bit patterns
        apply_config(CFG_RST);
        for (int i = 0; i < WIN_DEPTH; i++) begin
            case (i % 4)
                0: send_sample(ADC_W'(0));
                1: send_sample(ADC_W'(ADC_MAX));
                2: send_sample(12'hAAA);
                default: send_sample(12'h555);
            endcase
        end

        // Reset gains: push the average high then low, with one full drain
        send_sample(ADC_W'(ADC_MAX));
        send_sample(ADC_W'(ADC_MAX));
        drain_results();
        send_sample(ADC_W'(0));
        send_sample(ADC_W'(0));

        // Crossed duty limits, zero integral limit, large positive error
        c             = CFG_RST;
        c.setpoint    = ADC_W'(ADC_MAX);
        c.integ_limit = '0;
        c.duty_min    = DUTY_W'(40000);
        c.duty_max    = DUTY_W'(100);
        apply_config(c);
        repeat (3) send_sample(ADC_W'(0));

        // Crossed limits with the error at or below zero
        c.setpoint = '0;
        apply_config(c);
        repeat (3) send_sample(ADC_W'(ADC_MAX));

        // Every register at its maximum
        apply_config(make_config(CFG_KIND_FULL));
        send_sample(ADC_W'(0));
        send_sample(ADC_W'(ADC_MAX));
        send_sample(ADC_W'(0));

        // Random phases, one of them without any idling
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            apply_config(make_config(plan[ph]));
            idle_on <= (ph != 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 39) == 0) drain_results();
                send_sample(pick_sample(sb.cfg.setpoint));
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/mapd_pkg.sv
rtl/mapd_mul.sv
rtl/mapd_win.sv
rtl/mapd_ctrl.sv
rtl/moving_average_pid_duty_top.sv
rtl/mapd_chk.sv
sim/tb_top.sv
